// ----- rtl/triangle_unit_normal_assert.svh -----
// assertion macros shared by the triangle normal rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

// checked at every clock edge outside reset
`define TUN_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every clock edge, reset included
`define TUN_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- rtl/tun_pkg.sv -----
// shared constants and types of the triangle unit normal pipeline
// no dependencies
package tun_pkg;

  localparam int unsigned COORD_BITS_DEF       = 24;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 14;
  localparam int unsigned NORM_OUT_BITS        = 16;
  // magnitudes are cut down to this many bits before squaring
  localparam int unsigned NORM_KEEP_BITS       = 31;
  localparam int unsigned SUM_BITS             = 64;
  localparam int unsigned ROOT_BITS            = 32;
  localparam int unsigned SQRT_STEPS           = 32;
  localparam int unsigned SQ_BITS              = 2 * NORM_KEEP_BITS;

  // per item flags that ride along the pipeline
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tun_tag_t;

  // what the square root cells carry next to the radicand
  typedef struct packed {
    logic [2:0][NORM_KEEP_BITS-1:0] m;
    tun_tag_t                       tag;
  } tun_side_t;

endpackage

// ----- rtl/triangle_unit_normal.sv -----
// Unit face normal of a triangle, fully pipelined: one triangle per clock cycle
// while out_ready_i is high. The pipeline holds a chain of 32 square root cells (one
// root bit each) and a divider chain of NORMAL_FRAC_BITS + 1 cells (one quotient bit
// each); a full stage holds only while its successor holds, so a waiting result
// does not block items entering behind it. Results are signed Q1.NORMAL_FRAC_BITS,
// degenerate triangles give a zero normal with degenerate_o set.
// depends on tun_pkg, tun_sqrt_cell, tun_div_cell, triangle_unit_normal_assert.svh
module triangle_unit_normal #(
  parameter int unsigned COORD_BITS       = tun_pkg::COORD_BITS_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [COORD_BITS-1:0]             a_x_i,
  input  logic signed [COORD_BITS-1:0]             a_y_i,
  input  logic signed [COORD_BITS-1:0]             a_z_i,
  input  logic signed [COORD_BITS-1:0]             b_x_i,
  input  logic signed [COORD_BITS-1:0]             b_y_i,
  input  logic signed [COORD_BITS-1:0]             b_z_i,
  input  logic signed [COORD_BITS-1:0]             c_x_i,
  input  logic signed [COORD_BITS-1:0]             c_y_i,
  input  logic signed [COORD_BITS-1:0]             c_z_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [tun_pkg::NORM_OUT_BITS-1:0] norm_x_o,
  output logic signed [tun_pkg::NORM_OUT_BITS-1:0] norm_y_o,
  output logic signed [tun_pkg::NORM_OUT_BITS-1:0] norm_z_o,
  output logic                                     degenerate_o
);
  import tun_pkg::*;

  localparam int unsigned EW   = COORD_BITS + 1;
  localparam int unsigned PW   = 2 * EW;
  localparam int unsigned MW   = 2 * COORD_BITS + 2;
  localparam int unsigned LW   = $clog2(MW + 1);
  localparam int unsigned QW   = NORMAL_FRAC_BITS + 1;
  localparam int unsigned DW   = ROOT_BITS + QW;
  localparam int unsigned SQ0  = 7;
  localparam int unsigned PRE  = SQ0 + SQRT_STEPS;
  localparam int unsigned DV0  = PRE + 1;
  localparam int unsigned OUTS = DV0 + QW;
  localparam int unsigned NS   = OUTS + 1;

  // stage valid bits and hold chain
  logic [NS-1:0] valid_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = en[0];

  // edges from the first vertex
  logic signed [EW-1:0] e0_d [3], e1_d [3], e0_q [3], e1_q [3];

  always_comb begin
    e0_d[0] = EW'(b_x_i) - EW'(a_x_i);
    e0_d[1] = EW'(b_y_i) - EW'(a_y_i);
    e0_d[2] = EW'(b_z_i) - EW'(a_z_i);
    e1_d[0] = EW'(c_x_i) - EW'(a_x_i);
    e1_d[1] = EW'(c_y_i) - EW'(a_y_i);
    e1_d[2] = EW'(c_z_i) - EW'(a_z_i);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      e0_q <= e0_d;
      e1_q <= e1_d;
    end
  end

  // cross product partial products
  logic signed [PW-1:0] p_d [6], p_q [6];

  always_comb begin
    p_d[0] = e0_q[1] * e1_q[2];
    p_d[1] = e0_q[2] * e1_q[1];
    p_d[2] = e0_q[2] * e1_q[0];
    p_d[3] = e0_q[0] * e1_q[2];
    p_d[4] = e0_q[0] * e1_q[1];
    p_d[5] = e0_q[1] * e1_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_q <= p_d;
    end
  end

  // cross product components as sign and magnitude
  logic signed [PW:0] n_d [3];
  logic [MW-1:0]      mag_d [3], mag_q [3], mag2_q [3];
  logic [2:0]         neg_d, neg_q, neg2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_d[k]   = (PW+1)'(p_q[2*k]) - (PW+1)'(p_q[2*k+1]);
      neg_d[k] = n_d[k][PW];
      mag_d[k] = neg_d[k] ? MW'(-n_d[k]) : MW'(n_d[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  // bit length of the largest magnitude
  logic [MW-1:0] or_v;
  logic [LW-1:0] lz_d, lz_q;

  always_comb begin
    or_v = mag_q[0] | mag_q[1] | mag_q[2];
    lz_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (or_v[i]) lz_d = LW'(i + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      lz_q   <= lz_d;
      mag2_q <= mag_q;
      neg2_q <= neg_q;
    end
  end

  // scale magnitudes below the keep width
  logic [LW-1:0] sh;
  logic [MW-1:0] shifted [3];
  tun_side_t     side4_d, side4_q, side5_q, side6_q;

  always_comb begin
    sh = (lz_q > LW'(NORM_KEEP_BITS)) ? lz_q - LW'(NORM_KEEP_BITS) : '0;
    for (int k = 0; k < 3; k++) begin
      shifted[k]    = mag2_q[k] >> sh;
      side4_d.m[k]  = NORM_KEEP_BITS'(shifted[k]);
    end
    side4_d.tag.neg   = neg2_q;
    side4_d.tag.degen = (lz_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      side4_q <= side4_d;
    end
  end

  // squares
  logic [SQ_BITS-1:0] sq_q [3];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= SQ_BITS'(side4_q.m[k]) * SQ_BITS'(side4_q.m[k]);
      end
      side5_q <= side4_q;
    end
  end

  // sum of squares
  logic [SUM_BITS-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      sum_q   <= SUM_BITS'(sq_q[0]) + SUM_BITS'(sq_q[1]) + SUM_BITS'(sq_q[2]);
      side6_q <= side5_q;
    end
  end

  // square root chain
  logic [SUM_BITS-1:0] rad_w  [SQRT_STEPS+1];
  logic [SUM_BITS-1:0] root_w [SQRT_STEPS+1];
  tun_side_t           side_w [SQRT_STEPS+1];

  assign rad_w[0]  = sum_q;
  assign root_w[0] = '0;
  assign side_w[0] = side6_q;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    tun_sqrt_cell #(
      .BIT_POS(SUM_BITS - 2 - 2 * i)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en[SQ0+i]),
      .rad_i (rad_w[i]),
      .root_i(root_w[i]),
      .side_i(side_w[i]),
      .rad_o (rad_w[i+1]),
      .root_o(root_w[i+1]),
      .side_o(side_w[i+1])
    );
  end

  // dividend with half the length added for rounding
  logic [ROOT_BITS-1:0] len_v, len_q;
  logic [2:0][DW-1:0]   num_d, num_q;
  tun_tag_t             tag_q;

  always_comb begin
    len_v = ROOT_BITS'(root_w[SQRT_STEPS]);
    for (int k = 0; k < 3; k++) begin
      num_d[k] = (DW'(side_w[SQRT_STEPS].m[k]) << NORMAL_FRAC_BITS) + DW'(len_v >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[PRE]) begin
      len_q <= len_v;
      num_q <= num_d;
      tag_q <= side_w[SQRT_STEPS].tag;
    end
  end

  // divider chain, most significant quotient bit first
  logic [ROOT_BITS-1:0] len_w [QW+1];
  logic [2:0][DW-1:0]   rem_w [QW+1];
  logic [2:0][QW-1:0]   quo_w [QW+1];
  tun_tag_t             tag_w [QW+1];

  assign len_w[0] = len_q;
  assign rem_w[0] = num_q;
  assign quo_w[0] = '0;
  assign tag_w[0] = tag_q;

  for (genvar d = 0; d < QW; d++) begin : g_div
    tun_div_cell #(
      .DW (DW),
      .QW (QW),
      .BIT(QW - 1 - d)
    ) u_cell (
      .clk_i(clk_i),
      .en_i (en[DV0+d]),
      .len_i(len_w[d]),
      .rem_i(rem_w[d]),
      .quo_i(quo_w[d]),
      .tag_i(tag_w[d]),
      .len_o(len_w[d+1]),
      .rem_o(rem_w[d+1]),
      .quo_o(quo_w[d+1]),
      .tag_o(tag_w[d+1])
    );
  end

  // sign, saturation and degenerate masking
  function automatic logic [NORM_OUT_BITS-1:0] pack_out(
    input logic          neg,
    input logic [QW-1:0] quo
  );
    logic [31:0] qx;
    logic [NORM_OUT_BITS-1:0] res;
    qx = 32'(quo);
    if (neg && qx != '0) begin
      if (qx >= 32'(2 ** (NORM_OUT_BITS - 1))) res = {1'b1, {(NORM_OUT_BITS-1){1'b0}}};
      else res = -NORM_OUT_BITS'(qx);
    end else begin
      if (qx >= 32'(2 ** (NORM_OUT_BITS - 1))) res = {1'b0, {(NORM_OUT_BITS-1){1'b1}}};
      else res = NORM_OUT_BITS'(qx);
    end
    return res;
  endfunction

  logic [NORM_OUT_BITS-1:0] norm_d [3], norm_q [3];
  logic                     degen_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      norm_d[k] = tag_w[QW].degen ? '0 : pack_out(tag_w[QW].neg[k], quo_w[QW][k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUTS]) begin
      norm_q  <= norm_d;
      degen_q <= tag_w[QW].degen;
    end
  end

  assign out_valid_o  = valid_q[OUTS];
  assign norm_x_o     = norm_q[0];
  assign norm_y_o     = norm_q[1];
  assign norm_z_o     = norm_q[2];
  assign degenerate_o = degen_q;

  `include "triangle_unit_normal_assert.svh"

  `TUN_ASSERT(degen_zero_a, out_valid_o && degenerate_o |-> (norm_x_o == '0) && (norm_y_o == '0) && (norm_z_o == '0), "degenerate item with nonzero normal")
  `TUN_ASSERT(nondegen_nonzero_a, out_valid_o && !degenerate_o |-> (norm_x_o != '0) || (norm_y_o != '0) || (norm_z_o != '0), "normal of a proper triangle is zero")
  `TUN_ASSERT_ALWAYS(empty_out_ready_a, !out_valid_o |-> in_ready_o, "input stalled with empty output")
  `TUN_ASSERT(accept_fills_a, in_valid_i && in_ready_o |=> valid_q[0], "accepted item lost at entry")

endmodule

// ----- rtl/tun_sqrt_cell.sv -----
// one cell of the integer square root chain: settles one root bit
// depends on tun_pkg
module tun_sqrt_cell #(
  parameter int unsigned BIT_POS = 62
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [tun_pkg::SUM_BITS-1:0]  rad_i,
  input  logic [tun_pkg::SUM_BITS-1:0]  root_i,
  input  tun_pkg::tun_side_t            side_i,
  output logic [tun_pkg::SUM_BITS-1:0]  rad_o,
  output logic [tun_pkg::SUM_BITS-1:0]  root_o,
  output tun_pkg::tun_side_t            side_o
);
  import tun_pkg::*;

  logic [SUM_BITS-1:0] bit_v;
  logic [SUM_BITS-1:0] trial;
  logic [SUM_BITS-1:0] rad_d, root_d;

  // trial subtract of root plus the current bit
  always_comb begin
    bit_v = SUM_BITS'(1) << BIT_POS;
    trial = root_i + bit_v;
    if (rad_i >= trial) begin
      rad_d  = rad_i - trial;
      root_d = (root_i >> 1) + bit_v;
    end else begin
      rad_d  = rad_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_d;
      root_o <= root_d;
      side_o <= side_i;
    end
  end

endmodule

// ----- rtl/tun_div_cell.sv -----
// one cell of the restoring divider chain: one quotient bit for three lanes
// depends on tun_pkg
module tun_div_cell #(
  parameter int unsigned DW  = 47,
  parameter int unsigned QW  = 15,
  parameter int unsigned BIT = 14
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [tun_pkg::ROOT_BITS-1:0]  len_i,
  input  logic [2:0][DW-1:0]             rem_i,
  input  logic [2:0][QW-1:0]             quo_i,
  input  tun_pkg::tun_tag_t              tag_i,
  output logic [tun_pkg::ROOT_BITS-1:0]  len_o,
  output logic [2:0][DW-1:0]             rem_o,
  output logic [2:0][QW-1:0]             quo_o,
  output tun_pkg::tun_tag_t              tag_o
);
  import tun_pkg::*;

  logic [DW-1:0]      dvs;
  logic [2:0][DW-1:0] rem_d;
  logic [2:0][QW-1:0] quo_d;

  // compare and subtract the shifted divisor in each lane
  always_comb begin
    dvs   = DW'(len_i) << BIT;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int k = 0; k < 3; k++) begin
      if (rem_i[k] >= dvs) begin
        rem_d[k]      = rem_i[k] - dvs;
        quo_d[k][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_o <= len_i;
      rem_o <= rem_d;
      quo_o <= quo_d;
      tag_o <= tag_i;
    end
  end

endmodule
